### rtl/xte_pkg.sv
package xte_pkg;

  localparam int unsigned MaxSeq = 6;

  // ascii codes used in the escape sequences
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_O    = 8'h6F;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_Q    = 8'h71;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_U    = 8'h75;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] C0_LOW  = 8'h00;
  localparam logic [7:0] C0_HIGH = 8'h1F;

  // utf-8 of U+FFFD and the noncharacter tails
  localparam logic [7:0] UTF_EF = 8'hEF;
  localparam logic [7:0] UTF_BF = 8'hBF;
  localparam logic [7:0] UTF_BE = 8'hBE;
  localparam logic [7:0] UTF_BD = 8'hBD;

  typedef logic [2:0] xte_len_t;
  typedef logic [$clog2(MaxSeq)-1:0] xte_idx_t;

  // one input byte expanded into its output run
  typedef struct packed {
    logic [MaxSeq-1:0][7:0] bytes;
    xte_len_t               len;
    logic                   last;
  } xte_item_t;

endpackage

### rtl/xte_encoder.sv
module xte_encoder (
  input  logic [7:0]        raw_byte,
  input  logic [7:0]        hist_prev,
  input  logic [7:0]        hist_prev_prev,
  input  logic              str_last,
  output xte_pkg::xte_item_t item
);
  import xte_pkg::*;

  always_comb begin
    item       = '0;
    item.last  = str_last;
    item.len   = 3'd1;
    item.bytes[0] = raw_byte;
    case (raw_byte) inside
      CH_TAB, CH_LF, CH_CR: begin
        item.len = 3'd1;
      end
      [C0_LOW:C0_HIGH]: begin
        item.len      = 3'd3;
        item.bytes[0] = UTF_EF;
        item.bytes[1] = UTF_BF;
        item.bytes[2] = UTF_BD;
      end
      CH_QUOT: begin
        item.len      = 3'd6;
        item.bytes[0] = CH_AMP;
        item.bytes[1] = CH_Q;
        item.bytes[2] = CH_U;
        item.bytes[3] = CH_O;
        item.bytes[4] = CH_T;
        item.bytes[5] = CH_SEMI;
      end
      CH_AMP: begin
        item.len      = 3'd5;
        item.bytes[0] = CH_AMP;
        item.bytes[1] = CH_A;
        item.bytes[2] = CH_M;
        item.bytes[3] = CH_P;
        item.bytes[4] = CH_SEMI;
      end
      CH_LT: begin
        item.len      = 3'd4;
        item.bytes[0] = CH_AMP;
        item.bytes[1] = CH_L;
        item.bytes[2] = CH_T;
        item.bytes[3] = CH_SEMI;
      end
      CH_GT: begin
        item.len      = 3'd4;
        item.bytes[0] = CH_AMP;
        item.bytes[1] = CH_G;
        item.bytes[2] = CH_T;
        item.bytes[3] = CH_SEMI;
      end
      UTF_BE, UTF_BF: begin
        // U+FFFE / U+FFFF tail folds into U+FFFD
        if (hist_prev_prev == UTF_EF && hist_prev == UTF_BF) begin
          item.bytes[0] = UTF_BD;
        end
      end
      default: begin
        item.len = 3'd1;
      end
    endcase
  end

endmodule

### rtl/xte_emitter.sv
module xte_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld_valid,
  input  xte_pkg::xte_item_t ld_item,
  output logic               ld_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // out_byte
  output logic               out_tlast,  // run_last
  output logic               out_tuser   // string_end
);
  import xte_pkg::*;

  logic      hold_valid_r, hold_valid_nxt;
  xte_item_t hold_r, hold_nxt;
  xte_idx_t  idx_r, idx_nxt;
  logic      final_beat;
  logic      take;

  assign final_beat = ({1'b0, idx_r} + 4'd1) == {1'b0, hold_r.len};
  assign take       = hold_valid_r && out_tready;
  assign ld_ready   = !hold_valid_r || (out_tready && final_beat);

  assign out_tvalid = hold_valid_r;
  assign out_tdata  = hold_r.bytes[idx_r];
  assign out_tlast  = final_beat;
  assign out_tuser  = final_beat && hold_r.last;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    idx_nxt        = idx_r;
    if (take && !final_beat) begin
      idx_nxt = idx_r + 1'b1;
    end else if (take) begin
      hold_valid_nxt = 1'b0;
    end
    // new run loads when the current one ends or the holder is empty
    if (ld_valid && ld_ready) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = ld_item;
      idx_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      idx_r        <= idx_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

### rtl/xml_text_escaper.sv
// xml text escaper
//
// in_*  : raw utf-8 text, one byte per beat. in_tuser marks the first byte of a
//         string and clears the two-byte history; in_tlast marks its last byte.
// out_* : escaped text, one byte per beat. out_tlast closes the run of bytes
//         produced by one input byte; out_tuser is set on the final byte of
//         the whole string.
// an input byte expands to one to six output beats (&quot; is the longest).
// an input beat passes first through the input register, where the byte is
// classified against the history, and then through the run holder that
// drives the output port. plain bytes stream at one per cycle while out_tready
// is high; an escape holds the input until the run holder has stepped through
// its output bytes, one byte per cycle while out_tready is high. the input
// register takes a new beat while a run still waits.
// a stall on out_tready freezes the output beat and, once the input register
// is full, drops in_tready. synchronous reset empties both stages and clears
// the history to zero.
module xml_text_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tuser,   // string_start
  input  logic       in_tlast,   // string_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // string_end
);
  import xte_pkg::*;

  logic       a_valid_r, a_valid_nxt;
  logic [7:0] a_byte_r, a_byte_nxt;
  logic       a_start_r, a_start_nxt;
  logic       a_last_r, a_last_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] prev_prev_r, prev_prev_nxt;
  logic [7:0] eff_prev;
  logic [7:0] eff_prev_prev;
  logic       ld_ready;
  logic       a_move;
  xte_item_t  enc_item;

  // a string start sees a cleared history
  assign eff_prev      = a_start_r ? 8'h00 : prev_r;
  assign eff_prev_prev = a_start_r ? 8'h00 : prev_prev_r;

  assign a_move    = a_valid_r && ld_ready;
  assign in_tready = !a_valid_r || ld_ready;

  always_comb begin
    a_valid_nxt   = a_valid_r;
    a_byte_nxt    = a_byte_r;
    a_start_nxt   = a_start_r;
    a_last_nxt    = a_last_r;
    prev_nxt      = prev_r;
    prev_prev_nxt = prev_prev_r;
    if (a_move) begin
      a_valid_nxt   = 1'b0;
      prev_prev_nxt = eff_prev;
      prev_nxt      = a_byte_r;
    end
    if (in_tvalid && in_tready) begin
      a_valid_nxt = 1'b1;
      a_byte_nxt  = in_tdata;
      a_start_nxt = in_tuser;
      a_last_nxt  = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      prev_r      <= 8'h00;
      prev_prev_r <= 8'h00;
    end else begin
      a_valid_r   <= a_valid_nxt;
      prev_r      <= prev_nxt;
      prev_prev_r <= prev_prev_nxt;
    end
    a_byte_r  <= a_byte_nxt;
    a_start_r <= a_start_nxt;
    a_last_r  <= a_last_nxt;
  end

  xte_encoder u_encoder (
    .raw_byte       (a_byte_r),
    .hist_prev      (eff_prev),
    .hist_prev_prev (eff_prev_prev),
    .str_last       (a_last_r),
    .item           (enc_item)
  );

  xte_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (a_valid_r),
    .ld_item    (enc_item),
    .ld_ready   (ld_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
